[rtl/core/lnd_pkg.sv]
package lnd_pkg;

    localparam int LND_HEADER_DIGITS = 8;

    // Result queue: power-of-two depth, at least twice the largest header
    localparam int LND_QUEUE_DEPTH = 16;
    localparam int LND_QPTR_W      = $clog2(LND_QUEUE_DEPTH);
    localparam int LND_FILL_W      = $clog2(LND_QUEUE_DEPTH + 1);

    localparam int LND_COUNT_W = 27;
    localparam int LND_POS_W   = 6;
    localparam int LND_POS_MAX = 63;

    localparam logic [7:0] LND_NEWLINE    = 8'h0A;
    localparam logic [7:0] LND_SPACE      = 8'h20;
    localparam logic [7:0] LND_DIGIT_ZERO = 8'h30;
    localparam logic [7:0] LND_DIGIT_NINE = 8'h39;

    localparam int LND_TEXT_OFFSET = 20;
    localparam int LND_PREFIX_LEN  = 15;
    localparam int LND_SCHED_LEN   = 15;
    localparam int LND_DONE_LEN    = 14;

    localparam logic [8*LND_PREFIX_LEN-1:0] LND_TXT_PREFIX = {"BACKEND", "_MESSAGE"};
    localparam logic [8*LND_SCHED_LEN-1:0]  LND_TXT_SCHED  = {"SCHEDULE", "_CHANGE"};
    localparam logic [8*LND_DONE_LEN-1:0]   LND_TXT_DONE   = {"DONE", "_RECORDING"};

    localparam logic [1:0] KIND_OTHER    = 2'd0;
    localparam logic [1:0] KIND_SCHEDULE = 2'd1;
    localparam logic [1:0] KIND_RECORDED = 2'd2;
    localparam logic [1:0] KIND_BACKEND  = 2'd3;

    typedef struct packed {
        logic [7:0] data_byte;
        logic       has_byte;
        logic       last;
        logic       length_framed;
        logic [1:0] event_kind;
    } lnd_result_t;

    typedef struct packed {
        logic [LND_FILL_W-1:0] fill;
        logic                  room;
    } lnd_q_status_t;

    function automatic logic [7:0] prefix_char(input logic [3:0] idx);
        logic [7:0] c;
        c = 8'h00;
        if (int'(idx) < LND_PREFIX_LEN)
            c = LND_TXT_PREFIX[8*(LND_PREFIX_LEN-1-int'(idx)) +: 8];
        return c;
    endfunction

    function automatic logic [7:0] sched_char(input logic [3:0] idx);
        logic [7:0] c;
        c = 8'h00;
        if (int'(idx) < LND_SCHED_LEN)
            c = LND_TXT_SCHED[8*(LND_SCHED_LEN-1-int'(idx)) +: 8];
        return c;
    endfunction

    function automatic logic [7:0] done_char(input logic [3:0] idx);
        logic [7:0] c;
        c = 8'h00;
        if (int'(idx) < LND_DONE_LEN)
            c = LND_TXT_DONE[8*(LND_DONE_LEN-1-int'(idx)) +: 8];
        return c;
    endfunction

endpackage

[rtl/core/lnd_if.sv]
interface lnd_rx_if;
    logic       valid;
    logic       ready;
    logic [7:0] rx_byte;

    modport source (output valid, output rx_byte, input ready);
    modport sink   (input valid, input rx_byte, output ready);
endinterface

interface lnd_msg_if;
    logic       valid;
    logic       ready;
    logic [7:0] data_byte;
    logic       has_byte;
    logic       last;
    logic       length_framed;
    logic [1:0] event_kind;

    modport source (output valid, output data_byte, output has_byte, output last,
                    output length_framed, output event_kind, input ready);
    modport sink   (input valid, input data_byte, input has_byte, input last,
                    input length_framed, input event_kind, output ready);
endinterface

[rtl/core/lnd_parser.sv]
module lnd_parser
    import lnd_pkg::*;
#(
    parameter int HEADER_DIGITS = LND_HEADER_DIGITS
)
(
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               rx_valid,
    output logic                               rx_ready,
    input  logic [7:0]                         rx_byte,
    input  lnd_q_status_t                      q_status,
    output logic [$clog2(HEADER_DIGITS+1)-1:0] wr_count,
    output lnd_result_t                        wr_slots [HEADER_DIGITS]
);

    localparam int CW = $clog2(HEADER_DIGITS + 1);
    localparam int IW = $clog2(HEADER_DIGITS);

    typedef enum logic [2:0] {
        PH_LEAD   = 3'b001,
        PH_DIGITS = 3'b010,
        PH_AFTER  = 3'b100
    } phase_t;

    typedef struct packed {
        logic [2:0]           flags;
        logic [LND_POS_W-1:0] pos;
    } cls_t;

    localparam cls_t CLS_INIT = '{flags: 3'b111, pos: '0};

    function automatic cls_t classify(input cls_t c, input logic [7:0] b);
        cls_t                 n;
        logic [LND_POS_W-1:0] rel;
        n   = c;
        rel = c.pos - LND_POS_W'(LND_TEXT_OFFSET);
        if (int'(c.pos) < LND_PREFIX_LEN && b != prefix_char(c.pos[3:0]))
            n.flags[0] = 1'b0;
        if (int'(c.pos) >= LND_TEXT_OFFSET && int'(c.pos) < LND_TEXT_OFFSET + LND_SCHED_LEN
            && b != sched_char(rel[3:0]))
            n.flags[1] = 1'b0;
        if (int'(c.pos) >= LND_TEXT_OFFSET && int'(c.pos) < LND_TEXT_OFFSET + LND_DONE_LEN
            && b != done_char(rel[3:0]))
            n.flags[2] = 1'b0;
        if (int'(c.pos) < LND_POS_MAX)
            n.pos = c.pos + 1'b1;
        return n;
    endfunction

    function automatic logic [1:0] message_kind(input cls_t c);
        logic [1:0] k;
        if (!c.flags[0] || int'(c.pos) < LND_PREFIX_LEN)
            k = KIND_OTHER;
        else if (c.flags[1] && int'(c.pos) >= LND_TEXT_OFFSET + LND_SCHED_LEN)
            k = KIND_SCHEDULE;
        else if (c.flags[2] && int'(c.pos) >= LND_TEXT_OFFSET + LND_DONE_LEN)
            k = KIND_RECORDED;
        else
            k = KIND_BACKEND;
        return k;
    endfunction

    logic                   in_valid_reg, in_valid_next;
    logic [7:0]             in_byte_reg;
    logic [7:0]             held_bytes_reg [HEADER_DIGITS];
    logic [CW-1:0]          held_count_reg, held_count_next;
    logic [LND_COUNT_W-1:0] remaining_reg, remaining_next;
    logic [LND_COUNT_W-1:0] value_reg, value_next;
    phase_t                 phase_reg, phase_next;
    logic                   possible_reg, possible_next;
    logic                   past_reg, past_next;
    logic                   prefix_ok_reg, prefix_ok_next;
    cls_t                   cls_reg, cls_next;

    logic       rx_take;
    logic       step;
    logic       held_we;
    logic [7:0] b;
    logic [3:0] digit;
    cls_t       cls_step;

    assign step     = in_valid_reg && q_status.room;
    assign rx_ready = !in_valid_reg || step;
    assign rx_take  = rx_valid && rx_ready;
    assign b        = in_byte_reg;
    assign digit    = 4'(b - LND_DIGIT_ZERO);
    assign cls_step = classify(cls_reg, b);

    always_comb
    begin
        in_valid_next = in_valid_reg;
        if (rx_take)
            in_valid_next = 1'b1;
        else if (step)
            in_valid_next = 1'b0;
    end

    always_comb
    begin
        held_count_next = held_count_reg;
        remaining_next  = remaining_reg;
        value_next      = value_reg;
        phase_next      = phase_reg;
        possible_next   = possible_reg;
        past_next       = past_reg;
        prefix_ok_next  = prefix_ok_reg;
        cls_next        = cls_reg;
        held_we         = 1'b0;
        wr_count        = '0;

        for (int i = 0; i < HEADER_DIGITS; i++)
        begin
            wr_slots[i].data_byte     = (i == int'(held_count_reg)) ? b : held_bytes_reg[i];
            wr_slots[i].has_byte      = 1'b1;
            wr_slots[i].last          = 1'b0;
            wr_slots[i].length_framed = 1'b0;
            wr_slots[i].event_kind    = KIND_OTHER;
        end

        if (step)
        begin
            if (past_reg && remaining_reg != '0)
            begin
                wr_count                  = CW'(1);
                remaining_next            = remaining_reg - 1'b1;
                wr_slots[0].data_byte     = b;
                wr_slots[0].length_framed = 1'b1;
                cls_next                  = cls_step;
                if (remaining_reg == LND_COUNT_W'(1))
                begin
                    wr_slots[0].last       = 1'b1;
                    wr_slots[0].event_kind = message_kind(cls_step);
                    past_next              = 1'b0;
                    held_count_next        = '0;
                    value_next             = '0;
                    phase_next             = PH_LEAD;
                    possible_next          = 1'b1;
                    prefix_ok_next         = 1'b1;
                    cls_next               = CLS_INIT;
                end
            end
            else if (past_reg)
            begin
                wr_count = CW'(1);
                if (b == LND_NEWLINE)
                begin
                    wr_slots[0].data_byte  = 8'h00;
                    wr_slots[0].has_byte   = 1'b0;
                    wr_slots[0].last       = 1'b1;
                    wr_slots[0].event_kind = message_kind(cls_reg);
                    past_next              = 1'b0;
                    held_count_next        = '0;
                    value_next             = '0;
                    phase_next             = PH_LEAD;
                    possible_next          = 1'b1;
                    prefix_ok_next         = 1'b1;
                    cls_next               = CLS_INIT;
                end
                else
                begin
                    wr_slots[0].data_byte = b;
                    cls_next              = cls_step;
                end
            end
            else if (b == LND_NEWLINE)
            begin
                // Flush held bytes, then a bare end; too short for the prefix, so kind is other
                wr_count = CW'(held_count_reg + 1'b1);
                for (int i = 0; i < HEADER_DIGITS; i++)
                begin
                    if (i == int'(held_count_reg))
                    begin
                        wr_slots[i].data_byte = 8'h00;
                        wr_slots[i].has_byte  = 1'b0;
                        wr_slots[i].last      = 1'b1;
                    end
                end
                held_count_next = '0;
                value_next      = '0;
                phase_next      = PH_LEAD;
                possible_next   = 1'b1;
                prefix_ok_next  = 1'b1;
                cls_next        = CLS_INIT;
            end
            else
            begin
                held_we         = 1'b1;
                held_count_next = held_count_reg + 1'b1;
                prefix_ok_next  = prefix_ok_reg && (b == prefix_char(4'(held_count_reg)));
                if (b == LND_SPACE)
                begin
                    case (phase_reg)
                        PH_DIGITS: phase_next = PH_AFTER;
                        default:   phase_next = phase_reg;
                    endcase
                end
                else if (b >= LND_DIGIT_ZERO && b <= LND_DIGIT_NINE)
                begin
                    case (phase_reg)
                        PH_LEAD:
                        begin
                            phase_next = PH_DIGITS;
                            value_next = LND_COUNT_W'(digit);
                        end
                        PH_DIGITS:
                            value_next = (value_reg << 3) + (value_reg << 1)
                                         + LND_COUNT_W'(digit);
                        default:
                            value_next = value_reg;
                    endcase
                end
                else
                begin
                    possible_next = 1'b0;
                end

                if (int'(held_count_next) >= HEADER_DIGITS)
                begin
                    past_next = 1'b1;
                    if (possible_next && value_next != '0)
                    begin
                        remaining_next = value_next;
                    end
                    else
                    begin
                        // Not a length: send the held bytes on, now in newline mode
                        wr_count       = CW'(HEADER_DIGITS);
                        cls_next.flags = {cls_reg.flags[2:1], cls_reg.flags[0] && prefix_ok_next};
                        cls_next.pos   = LND_POS_W'(HEADER_DIGITS);
                    end
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg   <= 1'b0;
            held_count_reg <= '0;
            remaining_reg  <= '0;
            value_reg      <= '0;
            phase_reg      <= PH_LEAD;
            possible_reg   <= 1'b1;
            past_reg       <= 1'b0;
            prefix_ok_reg  <= 1'b1;
            cls_reg        <= CLS_INIT;
        end
        else
        begin
            in_valid_reg   <= in_valid_next;
            held_count_reg <= held_count_next;
            remaining_reg  <= remaining_next;
            value_reg      <= value_next;
            phase_reg      <= phase_next;
            possible_reg   <= possible_next;
            past_reg       <= past_next;
            prefix_ok_reg  <= prefix_ok_next;
            cls_reg        <= cls_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (rx_take)
            in_byte_reg <= rx_byte;
        if (held_we)
            held_bytes_reg[held_count_reg[IW-1:0]] <= b;
    end

endmodule

[rtl/core/lnd_result_queue.sv]
module lnd_result_queue
    import lnd_pkg::*;
#(
    parameter int HEADER_DIGITS = LND_HEADER_DIGITS
)
(
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic [$clog2(HEADER_DIGITS+1)-1:0] wr_count,
    input  lnd_result_t                        wr_slots [HEADER_DIGITS],
    output lnd_q_status_t                      q_status,
    output logic                               out_valid,
    input  logic                               out_ready,
    output lnd_result_t                        out_result
);

    lnd_result_t           mem_reg [LND_QUEUE_DEPTH];
    logic [LND_QPTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [LND_QPTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [LND_FILL_W-1:0] fill_reg, fill_next;
    logic                  pop;

    assign out_valid  = fill_reg != '0;
    assign out_result = mem_reg[rd_ptr_reg];
    assign pop        = out_valid && out_ready;

    // Room for the largest burst one request can cause
    assign q_status.fill = fill_reg;
    assign q_status.room = fill_reg <= LND_FILL_W'(LND_QUEUE_DEPTH - HEADER_DIGITS);

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg + LND_QPTR_W'(wr_count);
        rd_ptr_next = rd_ptr_reg + LND_QPTR_W'(pop);
        fill_next   = fill_reg + LND_FILL_W'(wr_count) - LND_FILL_W'(pop);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            fill_reg   <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            fill_reg   <= fill_next;
        end
    end

    always_ff @(posedge clk)
    begin
        for (int i = 0; i < HEADER_DIGITS; i++)
        begin
            if (i < int'(wr_count))
                mem_reg[wr_ptr_reg + LND_QPTR_W'(i)] <= wr_slots[i];
        end
    end

endmodule

[rtl/core/length_or_newline_deframer_core.sv]
// Channel  Dir  Payload                                              Accept
// rx       in   rx_byte[7:0]                                         valid && ready
// msg      out  data_byte[7:0] has_byte last length_framed           valid && ready
//               event_kind[1:0]
//
// One received byte is taken per cycle while the queue has room; it is registered before its
// results, up to HEADER_DIGITS, are written at once into a 16-entry result queue that drains
// one result per cycle while msg is ready; rx stalls while fewer than HEADER_DIGITS entries are
// free. Reset clears all message state and empties the queue; no clearing pass is needed. A
// stall on msg holds the queue head and backs up into rx only when under HEADER_DIGITS are free.
module length_or_newline_deframer_core
    import lnd_pkg::*;
#(
    parameter int HEADER_DIGITS = LND_HEADER_DIGITS
)
(
    input  logic  clk,
    input  logic  rst_n,
    lnd_rx_if.sink    rx,
    lnd_msg_if.source msg
);

    localparam int CW = $clog2(HEADER_DIGITS + 1);

    lnd_q_status_t q_status;
    logic [CW-1:0] wr_count;
    lnd_result_t   wr_slots [HEADER_DIGITS];
    lnd_result_t   out_result;
    logic          out_valid;

    lnd_parser #(
        .HEADER_DIGITS (HEADER_DIGITS)
    ) u_parser (
        .clk      (clk),
        .rst_n    (rst_n),
        .rx_valid (rx.valid),
        .rx_ready (rx.ready),
        .rx_byte  (rx.rx_byte),
        .q_status (q_status),
        .wr_count (wr_count),
        .wr_slots (wr_slots)
    );

    lnd_result_queue #(
        .HEADER_DIGITS (HEADER_DIGITS)
    ) u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .wr_count   (wr_count),
        .wr_slots   (wr_slots),
        .q_status   (q_status),
        .out_valid  (out_valid),
        .out_ready  (msg.ready),
        .out_result (out_result)
    );

    assign msg.valid         = out_valid;
    assign msg.data_byte     = out_result.data_byte;
    assign msg.has_byte      = out_result.has_byte;
    assign msg.last          = out_result.last;
    assign msg.length_framed = out_result.length_framed;
    assign msg.event_kind    = out_result.event_kind;

`ifndef SYNTHESIS
    a_fill_bound: assert property (@(posedge clk) disable iff (!rst_n)
        q_status.fill <= LND_FILL_W'(LND_QUEUE_DEPTH))
        else $error("result queue overfilled");

    a_write_room: assert property (@(posedge clk) disable iff (!rst_n)
        wr_count != '0 |-> q_status.room)
        else $error("results written without room in queue");

    a_bare_end: assert property (@(posedge clk) disable iff (!rst_n)
        msg.valid && !msg.has_byte |-> msg.last && !msg.length_framed)
        else $error("bare result that is not a newline-mode end");

    a_kind_on_last: assert property (@(posedge clk) disable iff (!rst_n)
        msg.valid && !msg.last |-> msg.event_kind == KIND_OTHER)
        else $error("event kind set on a result that does not end a message");
`endif

endmodule
